@@ rtl/dcm_pkg.sv @@
// Shared types, constants and helpers for the DC motor RK4 step unit.
package dcm_pkg;

    localparam int NUM_REGS = 6;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_FRICTION  = 3'd0;
    localparam logic [IDX_W-1:0] REG_INERTIA   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MOTOR_K   = 3'd2;
    localparam logic [IDX_W-1:0] REG_RESIST    = 3'd3;
    localparam logic [IDX_W-1:0] REG_INDUCT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_TIME = 3'd5;

    // RK4 stage kinds
    localparam int RK_K1 = 0;
    localparam int RK_K2 = 1;
    localparam int RK_K3 = 2;
    localparam int RK_K4 = 3;

    // divider: quotient bits per stage, stage count, total latency
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 32 / DIV_BITS;
    localparam int DIV_LAT    = DIV_STAGES + 2;

    // weighted sum f1 + 2f2 + 2f3 + f4; its magnitude stays below 2^34
    localparam int SUM_W = 35;
    localparam int MAG_W = 34;

    // floor(m / 6) = (m * RECIP6) >> RECIP6_SH for every m below 2^35
    localparam logic [33:0] RECIP6    = 34'h2AAAAAAAB;
    localparam int          RECIP6_SH = 36;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    typedef struct packed {
        logic [31:0] friction;
        logic [31:0] inertia;
        logic [31:0] motor_k;
        logic [31:0] resist;
        logic [31:0] induct;
        logic [31:0] step_time;
    } coef_t;

    // item context carried along the pipeline
    typedef struct packed {
        q_t x0;
        q_t x1;
        q_t x2;
        q_t v;
        q_t s0;
        q_t s1;
        q_t s2;
        logic signed [SUM_W-1:0] a0;
        logic signed [SUM_W-1:0] a1;
        logic signed [SUM_W-1:0] a2;
    } ctx_t;

    function automatic q_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return Q_MAX;
        end else if (v < -66'sd2147483648) begin
            return Q_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ rtl/dcm_div.sv @@
// Pipelined signed quotient (num << FRAC_BITS) / den with saturation.
module dcm_div
    import dcm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] num,
    input  logic        [31:0] den,
    output q_t                 quo
);

    logic [33:0] mag_abs;
    logic [63:0] nwide;

    logic [31:0] rem_reg [0:DIV_STAGES];
    logic [31:0] low_reg [0:DIV_STAGES];
    logic [31:0] den_reg [0:DIV_STAGES];
    logic        neg_reg [0:DIV_STAGES];
    logic        zero_reg [0:DIV_STAGES];
    logic        ovf_reg [0:DIV_STAGES];

    logic [31:0] rem_next [0:DIV_STAGES-1];
    logic [31:0] low_next [0:DIV_STAGES-1];

    q_t quo_reg;
    q_t quo_next;

    always_comb begin
        mag_abs = num[33] ? 34'(-num) : 34'(num);
        nwide   = 64'({mag_abs[32:0], {FRAC_BITS{1'b0}}});
    end

    // restoring steps; high word starts below den unless overflow is flagged
    always_comb begin
        logic [32:0] t;
        t = '0;
        for (int g = 0; g < DIV_STAGES; g++) begin
            rem_next[g] = rem_reg[g];
            low_next[g] = low_reg[g];
            for (int i = 0; i < DIV_BITS; i++) begin
                t = {rem_next[g], low_next[g][31]};
                if (t >= {1'b0, den_reg[g]}) begin
                    rem_next[g] = 32'(t - {1'b0, den_reg[g]});
                    low_next[g] = {low_next[g][30:0], 1'b1};
                end else begin
                    rem_next[g] = t[31:0];
                    low_next[g] = {low_next[g][30:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        if (zero_reg[DIV_STAGES]) begin
            quo_next = '0;
        end else if (ovf_reg[DIV_STAGES]) begin
            quo_next = neg_reg[DIV_STAGES] ? Q_MIN : Q_MAX;
        end else if (!neg_reg[DIV_STAGES]) begin
            quo_next = low_reg[DIV_STAGES][31] ? Q_MAX : q_t'(low_reg[DIV_STAGES]);
        end else begin
            quo_next = low_reg[DIV_STAGES][31] ? Q_MIN : q_t'(-low_reg[DIV_STAGES]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= nwide[63:32];
            low_reg[0]  <= nwide[31:0];
            den_reg[0]  <= den;
            neg_reg[0]  <= num[33];
            zero_reg[0] <= (num == 34'sd0);
            ovf_reg[0]  <= (nwide >= {den, 32'd0});
            for (int g = 0; g < DIV_STAGES; g++) begin
                rem_reg[g+1]  <= rem_next[g];
                low_reg[g+1]  <= low_next[g];
                den_reg[g+1]  <= den_reg[g];
                neg_reg[g+1]  <= neg_reg[g];
                zero_reg[g+1] <= zero_reg[g];
                ovf_reg[g+1]  <= ovf_reg[g];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

@@ rtl/dcm_deriv.sv @@
// One RK4 stage: derivatives, step-time scaling, weighted-sum accumulation and, but for K4, the next stage state.
module dcm_deriv
    import dcm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MODE      = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  coef_t coef,
    input  logic  in_valid,
    input  ctx_t  in_ctx,
    output logic  out_valid,
    output ctx_t  out_ctx
);

    // products of the stage state with the motor constants
    logic signed [64:0] pks2_reg, pbs1_reg, ps2r_reg, pks1_reg;
    logic               vld1_reg;
    ctx_t               ctx1_reg;

    logic signed [64:0] sh_ks2, sh_bs1, sh_s2r, sh_ks1;
    logic signed [33:0] t_ks2, t_bs1, t_s2r, t_ks1, t_v;
    logic signed [33:0] n1_next, n2_next, n1_reg, n2_reg;
    logic               vld2_reg;
    ctx_t               ctx2_reg;

    logic               vd_reg [0:DIV_LAT-1];
    ctx_t               cd_reg [0:DIV_LAT-1];
    q_t                 q1, q2;

    logic signed [64:0] p0_reg, p1_reg, p2_reg;
    logic               vld4_reg;
    ctx_t               ctx4_reg;

    q_t                      f0, f1, f2, h0, h1, h2;
    logic signed [SUM_W-1:0] e0, e1, e2;
    logic signed [32:0]      y0, y1, y2;
    ctx_t                    out_next;
    ctx_t                    out_reg;
    logic                    vout_reg;

    always_comb begin
        sh_ks2  = pks2_reg >>> FRAC_BITS;
        sh_bs1  = pbs1_reg >>> FRAC_BITS;
        sh_s2r  = ps2r_reg >>> FRAC_BITS;
        sh_ks1  = pks1_reg >>> FRAC_BITS;
        t_ks2   = 34'(sat32(66'(sh_ks2)));
        t_bs1   = 34'(sat32(66'(sh_bs1)));
        t_s2r   = 34'(sat32(66'(sh_s2r)));
        t_ks1   = 34'(sat32(66'(sh_ks1)));
        t_v     = 34'(ctx1_reg.v);
        n1_next = t_ks2 - t_bs1;
        n2_next = t_v - t_s2r - t_ks1;
    end

    dcm_div #(.FRAC_BITS(FRAC_BITS)) u_div_speed (
        .aclk (aclk),
        .en   (en),
        .num  (n1_reg),
        .den  (coef.inertia),
        .quo  (q1)
    );

    dcm_div #(.FRAC_BITS(FRAC_BITS)) u_div_current (
        .aclk (aclk),
        .en   (en),
        .num  (n2_reg),
        .den  (coef.induct),
        .quo  (q2)
    );

    always_comb begin
        f0 = p0_reg[63:32];
        f1 = p1_reg[63:32];
        f2 = p2_reg[63:32];
        h0 = f0 >>> 1;
        h1 = f1 >>> 1;
        h2 = f2 >>> 1;
        e0 = SUM_W'(f0);
        e1 = SUM_W'(f1);
        e2 = SUM_W'(f2);
        out_next = ctx4_reg;
        if (MODE == RK_K2 || MODE == RK_K3) begin
            out_next.a0 = ctx4_reg.a0 + e0 + e0;
            out_next.a1 = ctx4_reg.a1 + e1 + e1;
            out_next.a2 = ctx4_reg.a2 + e2 + e2;
        end else begin
            out_next.a0 = ctx4_reg.a0 + e0;
            out_next.a1 = ctx4_reg.a1 + e1;
            out_next.a2 = ctx4_reg.a2 + e2;
        end
        if (MODE == RK_K3) begin
            y0 = 33'(ctx4_reg.x0) + 33'(f0);
            y1 = 33'(ctx4_reg.x1) + 33'(f1);
            y2 = 33'(ctx4_reg.x2) + 33'(f2);
        end else begin
            y0 = 33'(ctx4_reg.x0) + 33'(h0);
            y1 = 33'(ctx4_reg.x1) + 33'(h1);
            y2 = 33'(ctx4_reg.x2) + 33'(h2);
        end
        if (MODE != RK_K4) begin
            out_next.s0 = sat32(66'(y0));
            out_next.s1 = sat32(66'(y1));
            out_next.s2 = sat32(66'(y2));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                vd_reg[i] <= 1'b0;
            end
            vld4_reg <= 1'b0;
            vout_reg <= 1'b0;
        end else if (en) begin
            vld1_reg  <= in_valid;
            vld2_reg  <= vld1_reg;
            vd_reg[0] <= vld2_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
            vld4_reg <= vd_reg[DIV_LAT-1];
            vout_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pks2_reg  <= 65'($signed({1'b0, coef.motor_k})) * 65'(in_ctx.s2);
            pbs1_reg  <= 65'($signed({1'b0, coef.friction})) * 65'(in_ctx.s1);
            ps2r_reg  <= 65'(in_ctx.s2) * 65'($signed({1'b0, coef.resist}));
            pks1_reg  <= 65'($signed({1'b0, coef.motor_k})) * 65'(in_ctx.s1);
            ctx1_reg  <= in_ctx;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            ctx2_reg  <= ctx1_reg;
            cd_reg[0] <= ctx2_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                cd_reg[i] <= cd_reg[i-1];
            end
            p0_reg   <= 65'(cd_reg[DIV_LAT-1].s1) * 65'($signed({1'b0, coef.step_time}));
            p1_reg   <= 65'(q1) * 65'($signed({1'b0, coef.step_time}));
            p2_reg   <= 65'(q2) * 65'($signed({1'b0, coef.step_time}));
            ctx4_reg <= cd_reg[DIV_LAT-1];
            out_reg  <= out_next;
        end
    end

    assign out_valid = vout_reg;
    assign out_ctx   = out_reg;

endmodule

@@ rtl/dcm_fin.sv @@
// Weighted sum divided by six, added to the start state and saturated.
module dcm_fin
    import dcm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  ctx_t in_ctx,
    output logic out_valid,
    output q_t   res0,
    output q_t   res1,
    output q_t   res2
);

    logic signed [SUM_W-1:0] acc [0:2];
    q_t                      xin [0:2];
    logic [MAG_W-1:0]        mag [0:2];

    // stage 1: magnitudes
    logic [MAG_W-1:0] mag_reg  [0:2];
    logic             neg1_reg [0:2];
    q_t               x1_reg   [0:2];
    logic             vld1_reg;

    // stage 2: 17 x 17 partial products of the reciprocal multiply
    logic [33:0] pp_hh_reg [0:2];
    logic [33:0] pp_hl_reg [0:2];
    logic [33:0] pp_lh_reg [0:2];
    logic [33:0] pp_ll_reg [0:2];
    logic        neg2_reg  [0:2];
    q_t          x2_reg    [0:2];
    logic        vld2_reg;

    // stage 3: quotient magnitudes
    logic [31:0] quo_next [0:2];
    logic [31:0] quo_reg  [0:2];
    logic        neg3_reg [0:2];
    q_t          x3_reg   [0:2];
    logic        vld3_reg;

    q_t   res_next [0:2];
    q_t   res_reg  [0:2];
    logic vout_reg;

    always_comb begin
        acc[0] = in_ctx.a0;
        acc[1] = in_ctx.a1;
        acc[2] = in_ctx.a2;
        xin[0] = in_ctx.x0;
        xin[1] = in_ctx.x1;
        xin[2] = in_ctx.x2;
    end

    always_comb begin
        logic [SUM_W-1:0] a;
        a = '0;
        for (int n = 0; n < 3; n++) begin
            a = acc[n][SUM_W-1] ? SUM_W'(-acc[n]) : SUM_W'(acc[n]);
            mag[n] = a[MAG_W-1:0];
        end
    end

    always_comb begin
        logic [34:0] mid;
        logic [67:0] full;
        mid  = '0;
        full = '0;
        for (int n = 0; n < 3; n++) begin
            mid  = 35'(pp_hl_reg[n]) + 35'(pp_lh_reg[n]);
            full = {pp_hh_reg[n], 34'd0} + (68'(mid) << 17) + 68'(pp_ll_reg[n]);
            quo_next[n] = full[RECIP6_SH +: 32];
        end
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    always_comb begin
        logic signed [32:0] qs;
        logic signed [33:0] xs;
        qs = '0;
        xs = '0;
        for (int n = 0; n < 3; n++) begin
            qs = $signed({1'b0, quo_reg[n]});
            if (neg3_reg[n]) begin
                qs = -qs;
            end
            xs = 34'(x3_reg[n]) + 34'(qs);
            res_next[n] = sat32(66'(xs));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vout_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vout_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < 3; n++) begin
                mag_reg[n]   <= mag[n];
                neg1_reg[n]  <= acc[n][SUM_W-1];
                x1_reg[n]    <= xin[n];
                pp_hh_reg[n] <= {17'd0, mag_reg[n][33:17]} * {17'd0, RECIP6[33:17]};
                pp_hl_reg[n] <= {17'd0, mag_reg[n][33:17]} * {17'd0, RECIP6[16:0]};
                pp_lh_reg[n] <= {17'd0, mag_reg[n][16:0]} * {17'd0, RECIP6[33:17]};
                pp_ll_reg[n] <= {17'd0, mag_reg[n][16:0]} * {17'd0, RECIP6[16:0]};
                neg2_reg[n]  <= neg1_reg[n];
                x2_reg[n]    <= x1_reg[n];
                quo_reg[n]   <= quo_next[n];
                neg3_reg[n]  <= neg2_reg[n];
                x3_reg[n]    <= x2_reg[n];
                res_reg[n]   <= res_next[n];
            end
        end
    end

    assign out_valid = vout_reg;
    assign res0      = res_reg[0];
    assign res1      = res_reg[1];
    assign res2      = res_reg[2];

endmodule

@@ rtl/dc_motor_rk4_step_unit.sv @@
// Top level of the DC motor RK4 step unit: config registers and stage chain.
//
//  channel  dir  handshake               payload
//  s_       in   s_tvalid / s_tready     s_tdata: angle, speed, current, voltage
//  m_       out  m_tvalid / m_tready     m_tdata: next_angle, next_speed, next_current
//  cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per cycle is taken while the output is not held; each result
// passes through four RK stages, each built around pipelined dividers, and then
// through the divide-by-six and final add.
// A held output freezes the whole pipeline; s_tready drops for that cycle.
// Synchronous reset clears valid bits and loads register defaults; no clearing pass.
module dc_motor_rk4_step_unit
    import dcm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [127:0]     s_tdata,   // angle, speed, current, voltage
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [95:0]      m_tdata,   // next_angle, next_speed, next_current
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data
);

    coef_t coef_reg;
    logic  en;
    ctx_t  ctx_in;
    ctx_t  ctx_st [0:3];
    logic  vld_st [0:3];
    q_t    r0, r1, r2;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.friction  <= '0;
            coef_reg.inertia   <= 32'd1 << FRAC_BITS;
            coef_reg.motor_k   <= '0;
            coef_reg.resist    <= '0;
            coef_reg.induct    <= 32'd1 << FRAC_BITS;
            coef_reg.step_time <= 32'd4294967;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRICTION:  coef_reg.friction  <= cfg_data;
                REG_INERTIA:   coef_reg.inertia   <= cfg_data;
                REG_MOTOR_K:   coef_reg.motor_k   <= cfg_data;
                REG_RESIST:    coef_reg.resist    <= cfg_data;
                REG_INDUCT:    coef_reg.induct    <= cfg_data;
                REG_STEP_TIME: coef_reg.step_time <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ctx_in.x0 = s_tdata[31:0];
        ctx_in.x1 = s_tdata[63:32];
        ctx_in.x2 = s_tdata[95:64];
        ctx_in.v  = s_tdata[127:96];
        ctx_in.s0 = s_tdata[31:0];
        ctx_in.s1 = s_tdata[63:32];
        ctx_in.s2 = s_tdata[95:64];
        ctx_in.a0 = '0;
        ctx_in.a1 = '0;
        ctx_in.a2 = '0;
    end

    dcm_deriv #(.FRAC_BITS(FRAC_BITS), .MODE(RK_K1)) u_k1 (
        .aclk (aclk), .aresetn (aresetn), .en (en), .coef (coef_reg),
        .in_valid (s_tvalid), .in_ctx (ctx_in),
        .out_valid (vld_st[0]), .out_ctx (ctx_st[0])
    );

    dcm_deriv #(.FRAC_BITS(FRAC_BITS), .MODE(RK_K2)) u_k2 (
        .aclk (aclk), .aresetn (aresetn), .en (en), .coef (coef_reg),
        .in_valid (vld_st[0]), .in_ctx (ctx_st[0]),
        .out_valid (vld_st[1]), .out_ctx (ctx_st[1])
    );

    dcm_deriv #(.FRAC_BITS(FRAC_BITS), .MODE(RK_K3)) u_k3 (
        .aclk (aclk), .aresetn (aresetn), .en (en), .coef (coef_reg),
        .in_valid (vld_st[1]), .in_ctx (ctx_st[1]),
        .out_valid (vld_st[2]), .out_ctx (ctx_st[2])
    );

    dcm_deriv #(.FRAC_BITS(FRAC_BITS), .MODE(RK_K4)) u_k4 (
        .aclk (aclk), .aresetn (aresetn), .en (en), .coef (coef_reg),
        .in_valid (vld_st[2]), .in_ctx (ctx_st[2]),
        .out_valid (vld_st[3]), .out_ctx (ctx_st[3])
    );

    dcm_fin u_fin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_st[3]),
        .in_ctx    (ctx_st[3]),
        .out_valid (m_tvalid),
        .res0      (r0),
        .res1      (r1),
        .res2      (r2)
    );

    assign m_tdata = {r2, r1, r0};

endmodule

@@ rtl/dcm_checker.sv @@
// Port-level assertions for the DC motor RK4 step unit, bound to the top level.
module dcm_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a held result keeps its valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // a held result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // input side takes a transaction exactly when the pipeline can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow pipeline advance");

    // reset empties the pipeline: no result valid follows it
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind dc_motor_rk4_step_unit dcm_assert u_dcm_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
